// ===== hdl/chist_pkg.sv =====
`default_nettype none

package chist_pkg;

    localparam int CLASSES    = 256;
    localparam int CIDX_W     = (CLASSES > 1) ? $clog2(CLASSES) : 1;
    localparam int SCAN_W     = $clog2(CLASSES + 1);
    localparam int CNT_W      = 32;
    localparam int TOT_W      = 40;
    localparam int CFG_W      = 9;
    localparam int IDX_W      = 8;
    localparam int DOM_W      = 8;
    localparam int STAT_W     = 2;

    localparam logic [CFG_W-1:0]  CFG_RESET = 9'd256;
    localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

    localparam logic              CMD_INC   = 1'b0;
    localparam logic              CMD_CLR   = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT    = 2'd2;

    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] cls_sel;
    } in_word_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  class_total;
        logic [TOT_W-1:0]  sample_total;
        logic [DOM_W-1:0]  dominant_class;
    } out_word_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              clr_all;
        logic              load;
        logic              in_range;
        logic              op_clear;
        logic [CIDX_W-1:0] idx;
    } cell_cmd_t;

    // running maximum handed down the row
    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [CIDX_W-1:0] idx;
    } scan_t;

endpackage

`default_nettype wire

// ===== hdl/class_histogram_with_argmax.sv =====
`default_nettype none

// channel  | ports                          | word
// ---------+--------------------------------+---------------------------------------
// cfg      | cfg_wr_en, cfg_wr_data         | class limit, clears all counts
// in       | s_valid, s_ready, s_data       | cmd, cls_sel
// out      | m_valid, m_ready, m_data       | status, class_total, sample_total, dom
//
// One word per cycle sustained while the output is free and no rescan runs; the word and the
// addressed cell's old count are registered first, then its result goes to the output register.
// Counts live in a row of cells, one per class; the dominant class is tracked incrementally,
// except a clear of the leading class, which runs the max down the cell row, input held low.
// Synchronous active-low reset clears all counts, total and sets the class limit to 256.
// A stalled output holds its word and stops the input after one more word.

module class_histogram_with_argmax
    import chist_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_word_t         s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_word_t             m_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CFG_W-1:0]  ccount_reg, ccount_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  best_cnt_reg, best_cnt_next;
    logic [CIDX_W-1:0] best_idx_reg, best_idx_next;
    logic [SCAN_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic              op_cmd_reg, op_cmd_next;
    logic [CIDX_W-1:0] op_idx_reg, op_idx_next;
    logic              op_ok_reg, op_ok_next;
    logic              m_valid_reg, m_valid_next;
    out_word_t         m_data_reg, m_data_next;

    cell_cmd_t         cell_cmd;
    logic [CNT_W-1:0]  old_cnt;
    scan_t             scan_tail;

    logic              accept, out_free, in_range;
    logic              is_inc, sat, bump, need_rescan, new_lead;
    logic [CNT_W-1:0]  new_cnt;
    logic [TOT_W-1:0]  upd_total;
    out_word_t         upd_word;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign in_range = (32'(s_data.cls_sel) < CLASSES)
                   && ({1'b0, s_data.cls_sel} < ccount_reg);

    assign cell_cmd.clr_all  = cfg_wr_en;
    assign cell_cmd.load     = accept;
    assign cell_cmd.in_range = in_range;
    assign cell_cmd.op_clear = (s_data.cmd == CMD_CLR);
    assign cell_cmd.idx      = CIDX_W'(s_data.cls_sel);

    chist_row u_row (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cell_cmd),
        .rd_cnt    (old_cnt),
        .scan_tail (scan_tail)
    );

    // result of the word sitting in S_UPD
    always_comb begin
        is_inc      = (op_cmd_reg == CMD_INC);
        sat         = (old_cnt == CNT_MAX);
        new_cnt     = old_cnt + 1'b1;
        bump        = op_ok_reg && is_inc && !sat;
        need_rescan = op_ok_reg && !is_inc && (op_idx_reg == best_idx_reg)
                   && (best_cnt_reg != '0);
        new_lead    = bump && ((new_cnt > best_cnt_reg)
                   || ((new_cnt == best_cnt_reg) && (op_idx_reg < best_idx_reg)));

        upd_total = total_reg;
        if (bump) begin
            upd_total = total_reg + 1'b1;
        end else if (op_ok_reg && !is_inc) begin
            upd_total = total_reg - {{(TOT_W-CNT_W){1'b0}}, old_cnt};
        end

        upd_word.sample_total   = upd_total;
        upd_word.dominant_class = new_lead ? DOM_W'(op_idx_reg) : DOM_W'(best_idx_reg);
        if (!op_ok_reg) begin
            upd_word.status      = ST_RANGE;
            upd_word.class_total = '0;
        end else if (!is_inc) begin
            upd_word.status      = ST_DONE;
            upd_word.class_total = '0;
        end else if (sat) begin
            upd_word.status      = ST_SAT;
            upd_word.class_total = old_cnt;
        end else begin
            upd_word.status      = ST_DONE;
            upd_word.class_total = new_cnt;
        end
    end

    always_comb begin
        unique case (state_reg)
            S_IDLE:  s_ready = 1'b1;
            S_UPD:   s_ready = out_free && !need_rescan;
            default: s_ready = 1'b0;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        ccount_next   = ccount_reg;
        total_next    = total_reg;
        best_cnt_next = best_cnt_reg;
        best_idx_next = best_idx_reg;
        scan_cnt_next = scan_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        op_cmd_next   = op_cmd_reg;
        op_idx_next   = op_idx_reg;
        op_ok_next    = op_ok_reg;

        if (accept) begin
            op_cmd_next = s_data.cmd;
            op_idx_next = CIDX_W'(s_data.cls_sel);
            op_ok_next  = in_range;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                if (need_rescan) begin
                    total_next    = upd_total;
                    scan_cnt_next = SCAN_W'(1);
                    state_next    = S_SCAN;
                end else if (out_free) begin
                    total_next   = upd_total;
                    m_valid_next = 1'b1;
                    m_data_next  = upd_word;
                    if (new_lead) begin
                        best_cnt_next = new_cnt;
                        best_idx_next = op_idx_reg;
                    end
                    state_next = accept ? S_UPD : S_IDLE;
                end
            end
            S_SCAN: begin
                // tail is settled once every cell has seen the frozen counts
                if (scan_cnt_reg == SCAN_W'(CLASSES)) begin
                    if (out_free) begin
                        best_cnt_next              = scan_tail.cnt;
                        best_idx_next              = scan_tail.idx;
                        m_valid_next               = 1'b1;
                        m_data_next.status         = ST_DONE;
                        m_data_next.class_total    = '0;
                        m_data_next.sample_total   = total_reg;
                        m_data_next.dominant_class = DOM_W'(scan_tail.idx);
                        state_next                 = S_IDLE;
                    end
                end else begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cfg_wr_en) begin
            ccount_next   = cfg_wr_data;
            total_next    = '0;
            best_cnt_next = '0;
            best_idx_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ccount_reg   <= CFG_RESET;
            total_reg    <= '0;
            best_cnt_reg <= '0;
            best_idx_reg <= '0;
            scan_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ccount_reg   <= ccount_next;
            total_reg    <= total_next;
            best_cnt_reg <= best_cnt_next;
            best_idx_reg <= best_idx_next;
            scan_cnt_reg <= scan_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        op_cmd_reg <= op_cmd_next;
        op_idx_reg <= op_idx_next;
        op_ok_reg  <= op_ok_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_no_accept_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> !s_ready)
        else $error("word accepted during rescan");

    a_sat_reports_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == ST_SAT)) |-> (m_data.class_total == CNT_MAX))
        else $error("saturated status without full count");

    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == ST_RANGE)) |-> (m_data.class_total == '0))
        else $error("rejected word reports a count");

    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> ((total_reg == '0) && (best_cnt_reg == '0)))
        else $error("class limit write did not clear the store");

    a_zero_lead: assert property (@(posedge aclk) disable iff (!aresetn)
        (best_cnt_reg == '0) |-> (best_idx_reg == '0))
        else $error("leader index set with empty histogram");
`endif

endmodule

`default_nettype wire

// ===== hdl/chist_cell.sv =====
`default_nettype none

module chist_cell
    import chist_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [CIDX_W-1:0] cell_idx,
    input  wire cell_cmd_t         cmd,
    input  wire scan_t             scan_in,
    output scan_t                  scan_out,
    output logic [CNT_W-1:0]       rd_cnt
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_reg, rd_next;
    scan_t            scan_reg, scan_next;
    logic             hit;

    assign hit = cmd.load && cmd.in_range && (cmd.idx == cell_idx);

    always_comb begin
        count_next = count_reg;
        if (cmd.clr_all) begin
            count_next = '0;
        end else if (hit) begin
            if (cmd.op_clear) begin
                count_next = '0;
            end else if (count_reg != CNT_MAX) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // old count of the addressed cell, zero everywhere else
    always_comb begin
        rd_next = rd_reg;
        if (cmd.load) begin
            rd_next = hit ? count_reg : '0;
        end
    end

    // strict compare keeps the lower index on ties
    always_comb begin
        if (count_reg > scan_in.cnt) begin
            scan_next.cnt = count_reg;
            scan_next.idx = cell_idx;
        end else begin
            scan_next = scan_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg   <= rd_next;
        scan_reg <= scan_next;
    end

    assign scan_out = scan_reg;
    assign rd_cnt   = rd_reg;

endmodule

`default_nettype wire

// ===== hdl/chist_row.sv =====
`default_nettype none

module chist_row
    import chist_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cell_cmd_t   cmd,
    output logic [CNT_W-1:0] rd_cnt,
    output scan_t            scan_tail
);

    scan_t            scan_link [CLASSES+1];
    logic [CNT_W-1:0] cell_rd   [CLASSES];

    assign scan_link[0] = '0;

    for (genvar k = 0; k < CLASSES; k++) begin : g_cell
        chist_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (CIDX_W'(k)),
            .cmd      (cmd),
            .scan_in  (scan_link[k]),
            .scan_out (scan_link[k+1]),
            .rd_cnt   (cell_rd[k])
        );
    end

    // at most one cell holds a nonzero read word
    always_comb begin
        rd_cnt = '0;
        for (int k = 0; k < CLASSES; k++) begin
            rd_cnt = rd_cnt | cell_rd[k];
        end
    end

    assign scan_tail = scan_link[CLASSES];

endmodule

`default_nettype wire
